@@ sv/kci_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kci_pkg
// Shared widths, command codes and the keyframe table entry type.
// ----------------------------------------------------------------------------
package kci_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int IDX_W     = $clog2(MAX_KEYS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int FRAME_W   = 32;
    localparam int COORD_W   = 13;
    localparam int SCOORD_W  = COORD_W + 1;
    localparam int ACC_W     = FRAME_W + COORD_W;
    localparam int STEP_W    = $clog2(COORD_W);
    localparam int LANES     = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_key;

endpackage
`default_nettype wire

@@ sv/kci_lerp_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kci_lerp_lane
// Bit-serial lerp of one coordinate: a + floor(d * (b - a) / den).
// Shift-add multiply over the bits of |b - a|, then restoring division,
// one bit per cycle, in one shared accumulator.
// ----------------------------------------------------------------------------
module kci_lerp_lane (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire  [kci_pkg::COORD_W-1:0]   i_a,
    input  wire  [kci_pkg::COORD_W-1:0]   i_b,
    input  wire  [kci_pkg::FRAME_W-1:0]   i_d,
    input  wire  [kci_pkg::FRAME_W-1:0]   i_den,
    output logic                          o_done,
    output logic [kci_pkg::COORD_W-1:0]   o_value
);

    localparam int CW = kci_pkg::COORD_W;
    localparam int FW = kci_pkg::FRAME_W;
    localparam int AW = kci_pkg::ACC_W;
    localparam int SW = kci_pkg::STEP_W;
    localparam logic [SW-1:0] LAST_STEP = SW'(CW - 1);

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIX
    } t_lane_state;

    t_lane_state    r_state;
    logic [SW-1:0]  r_cnt;
    logic [AW-1:0]  r_acc;
    logic [CW-1:0]  r_m;
    logic           r_neg;
    logic [CW-1:0]  r_a;
    logic [FW-1:0]  r_d;
    logic [FW-1:0]  r_den;
    logic [CW-1:0]  r_value;
    logic           r_done;

    logic [AW-1:0]  n_mul_acc;
    logic [FW:0]    n_trial;
    logic [FW:0]    n_sub;
    logic           n_ge;
    logic [FW-1:0]  n_rem;
    logic [CW-1:0]  n_fix;
    logic           n_rem_nz;

    always_comb begin
        n_mul_acc = {r_acc[AW-2:0], 1'b0} + (r_m[CW-1] ? AW'(r_d) : '0);
        n_trial   = {r_acc[AW-1:CW], r_acc[CW-1]};
        n_sub     = n_trial - {1'b0, r_den};
        n_ge      = (n_trial >= {1'b0, r_den});
        n_rem     = n_ge ? n_sub[FW-1:0] : n_trial[FW-1:0];
        n_rem_nz  = |r_acc[AW-1:CW];
        if (r_neg) begin
            n_fix = r_a - r_acc[CW-1:0] - CW'(n_rem_nz);
        end else begin
            n_fix = r_a + r_acc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_neg   <= (i_b < i_a);
                        r_m     <= (i_b < i_a) ? (i_a - i_b) : (i_b - i_a);
                        r_d     <= i_d;
                        r_den   <= i_den;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_acc <= n_mul_acc;
                    r_m   <= {r_m[CW-2:0], 1'b0};
                    if (r_cnt == LAST_STEP) begin
                        r_cnt   <= '0;
                        r_state <= L_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                L_DIV: begin
                    r_acc <= {n_rem, r_acc[CW-2:0], n_ge};
                    if (r_cnt == LAST_STEP) begin
                        r_cnt   <= '0;
                        r_state <= L_FIX;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                L_FIX: begin
                    r_value <= n_fix;
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == L_IDLE)
        else $error("lane started while busy");

    a_done_after_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == L_FIX)
        else $error("lane done without fixup");

    a_value_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_neg ? (r_value <= r_a) : (r_value >= r_a)))
        else $error("lane result on wrong side of start value");

endmodule
`default_nettype wire

@@ sv/keyframe_crop_interpolator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_crop_interpolator_unit
// Keyframe table, segment scan and crop rectangle output.
// ----------------------------------------------------------------------------
// A keyframe write (i_cmd = 0) is taken while idle and leaves busy low.
// A frame item (i_cmd = 1) raises busy, steps the segment past each keyframe
// it has reached (S_SCAN, S_SCAN_CHK), reads the current keyframe (S_RD_CUR,
// S_CUR_CHK), holds it when last valid or not yet reached, else interpolates
// (S_LERP_GO, S_LERP_WAIT) toward the next one: the table has one read port, and
// four lanes each run 13 multiply steps and 13 divide steps, one bit a cycle.
// The result is shown for one cycle with o_valid and cannot be stalled.
// ----------------------------------------------------------------------------
module keyframe_crop_interpolator_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire                            i_cfg_we,
    input  wire  [kci_pkg::CNT_W-1:0]      i_cfg_data,
    input  wire                            i_cmd,
    input  wire  [kci_pkg::IDX_W-1:0]      i_key_index,
    input  wire  [kci_pkg::FRAME_W-1:0]    i_key_frame,
    input  wire  [kci_pkg::COORD_W-1:0]    i_key_center_x,
    input  wire  [kci_pkg::COORD_W-1:0]    i_key_center_y,
    input  wire  [kci_pkg::COORD_W-1:0]    i_key_width,
    input  wire  [kci_pkg::COORD_W-1:0]    i_key_height,
    output logic                           o_valid,
    output logic signed [kci_pkg::SCOORD_W-1:0] o_crop_left,
    output logic signed [kci_pkg::SCOORD_W-1:0] o_crop_top,
    output logic [kci_pkg::COORD_W-1:0]    o_crop_width,
    output logic [kci_pkg::COORD_W-1:0]    o_crop_height,
    output logic [kci_pkg::FRAME_W-1:0]    o_frame_number
);

    localparam int CW  = kci_pkg::COORD_W;
    localparam int SCW = kci_pkg::SCOORD_W;
    localparam int FW  = kci_pkg::FRAME_W;
    localparam int IW  = kci_pkg::IDX_W;
    localparam int NW  = kci_pkg::CNT_W;
    localparam int NK  = kci_pkg::MAX_KEYS;
    localparam int NL  = kci_pkg::LANES;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_CHK,
        S_RD_CUR,
        S_CUR_CHK,
        S_LERP_GO,
        S_LERP_WAIT
    } t_state;

    t_state                r_state;
    logic [NW-1:0]         r_count;
    logic [IW-1:0]         r_seg;
    logic [IW-1:0]         r_last;
    logic [FW-1:0]         r_fc;
    logic                  r_has_next;
    kci_pkg::t_key         r_mem [NK];
    kci_pkg::t_key         r_rd_data;
    kci_pkg::t_key         r_cur;
    kci_pkg::t_key         r_nxt;
    logic [FW-1:0]         r_d;
    logic [FW-1:0]         r_den;
    logic                  r_valid;
    logic [SCW-1:0]        r_left;
    logic [SCW-1:0]        r_top;
    logic [CW-1:0]         r_width;
    logic [CW-1:0]         r_height;
    logic [FW-1:0]         r_frame;

    logic                  w_accept;
    logic                  w_write;
    logic [IW-1:0]         w_rd_addr;
    logic [IW-1:0]         w_last;
    logic [CW-1:0]         w_lane_a [NL];
    logic [CW-1:0]         w_lane_b [NL];
    logic [CW-1:0]         w_lane_v [NL];
    logic [NL-1:0]         w_lane_done;
    logic [CW-1:0]         w_cx;
    logic [CW-1:0]         w_cy;
    logic [CW-1:0]         w_w;
    logic [CW-1:0]         w_h;
    logic                  w_interp;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_write  = w_accept && (i_cmd == kci_pkg::CMD_WRITE);

    always_comb begin
        if (r_count <= NW'(1)) begin
            w_last = '0;
        end else if (r_count >= NW'(NK)) begin
            w_last = IW'(NK - 1);
        end else begin
            w_last = IW'(r_count - 1'b1);
        end
    end

    assign w_rd_addr = (r_state == S_SCAN) ? (r_seg + 1'b1) : r_seg;
    assign w_interp  = r_has_next && (r_fc >= r_rd_data.frame);

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[i_key_index] <= '{frame: i_key_frame, cx: i_key_center_x,
                                    cy: i_key_center_y, w: i_key_width,
                                    h: i_key_height};
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign w_lane_a[0] = r_cur.cx;
    assign w_lane_a[1] = r_cur.cy;
    assign w_lane_a[2] = r_cur.w;
    assign w_lane_a[3] = r_cur.h;
    assign w_lane_b[0] = r_nxt.cx;
    assign w_lane_b[1] = r_nxt.cy;
    assign w_lane_b[2] = r_nxt.w;
    assign w_lane_b[3] = r_nxt.h;

    for (genvar g = 0; g < NL; g++) begin : g_lane
        kci_lerp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_state == S_LERP_GO),
            .i_a     (w_lane_a[g]),
            .i_b     (w_lane_b[g]),
            .i_d     (r_d),
            .i_den   (r_den),
            .o_done  (w_lane_done[g]),
            .o_value (w_lane_v[g])
        );
    end

    always_comb begin
        if (r_state == S_LERP_WAIT) begin
            w_cx = w_lane_v[0];
            w_cy = w_lane_v[1];
            w_w  = w_lane_v[2];
            w_h  = w_lane_v[3];
        end else begin
            w_cx = r_rd_data.cx;
            w_cy = r_rd_data.cy;
            w_w  = r_rd_data.w;
            w_h  = r_rd_data.h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= NW'(1);
            r_seg      <= '0;
            r_last     <= '0;
            r_fc       <= '0;
            r_has_next <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_cmd == kci_pkg::CMD_FRAME)) begin
                        r_last  <= w_last;
                        r_seg   <= (r_seg > w_last) ? w_last : r_seg;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_seg < r_last) begin
                        r_state <= S_SCAN_CHK;
                    end else begin
                        r_has_next <= 1'b0;
                        r_state    <= S_RD_CUR;
                    end
                end
                S_SCAN_CHK: begin
                    if (r_fc >= r_rd_data.frame) begin
                        r_seg   <= r_seg + 1'b1;
                        r_state <= S_SCAN;
                    end else begin
                        r_nxt      <= r_rd_data;
                        r_has_next <= 1'b1;
                        r_state    <= S_RD_CUR;
                    end
                end
                S_RD_CUR: begin
                    r_state <= S_CUR_CHK;
                end
                S_CUR_CHK: begin
                    if (w_interp) begin
                        r_cur   <= r_rd_data;
                        r_d     <= r_fc - r_rd_data.frame;
                        r_den   <= r_nxt.frame - r_rd_data.frame;
                        r_state <= S_LERP_GO;
                    end else begin
                        r_valid  <= 1'b1;
                        r_left   <= {1'b0, w_cx} - {2'b0, w_w[CW-1:1]};
                        r_top    <= {1'b0, w_cy} - {2'b0, w_h[CW-1:1]};
                        r_width  <= w_w;
                        r_height <= w_h;
                        r_frame  <= r_fc;
                        r_fc     <= r_fc + 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_LERP_GO: begin
                    r_state <= S_LERP_WAIT;
                end
                S_LERP_WAIT: begin
                    if (w_lane_done[0]) begin
                        r_valid  <= 1'b1;
                        r_left   <= {1'b0, w_cx} - {2'b0, w_w[CW-1:1]};
                        r_top    <= {1'b0, w_cy} - {2'b0, w_h[CW-1:1]};
                        r_width  <= w_w;
                        r_height <= w_h;
                        r_frame  <= r_fc;
                        r_fc     <= r_fc + 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_crop_left    = $signed(r_left);
    assign o_crop_top     = $signed(r_top);
    assign o_crop_width   = r_width;
    assign o_crop_height  = r_height;
    assign o_frame_number = r_frame;

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_SCAN) |-> r_seg <= r_last)
        else $error("segment index past last keyframe");

    a_fc_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_fc == r_frame + 1'b1)
        else $error("frame counter out of step with result");

    a_lanes_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lane_done != '0) |-> (w_lane_done == '1 && r_state == S_LERP_WAIT))
        else $error("lanes finished apart or out of sequence");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for two cycles");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: keyframe crop interpolator testbench
// Loads crop keyframe tables, sets the keyframe count while the unit is idle
// and steps video frames through it. Every frame item is predicted from a
// local copy of the table, segment and frame counter. The predicted rectangle
// is compared field by field with the one the unit emits. Directed corner items
// come first, then random table phases with noise writes and idling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDX_W    = kci_pkg::IDX_W;
    localparam int CNT_W    = kci_pkg::CNT_W;
    localparam int FRAME_W  = kci_pkg::FRAME_W;
    localparam int COORD_W  = kci_pkg::COORD_W;
    localparam int SCOORD_W = kci_pkg::SCOORD_W;
    localparam int MAX_KEYS = kci_pkg::MAX_KEYS;

    localparam int ITEM_TARGET = 1050;
    localparam int GUARD       = 4;
    localparam int TAIL        = 200;
    localparam int STALL_LIMIT = 5000;

    typedef enum logic [1:0] {STEP_ITEM, STEP_CONFIG, STEP_DRAIN} t_step_kind;

    typedef struct {
        t_step_kind          kind;
        logic                cmd;
        logic [IDX_W-1:0]    idx;
        kci_pkg::t_key       key;
        logic [CNT_W-1:0]    cfg;
    } t_step;

    typedef struct {
        logic [SCOORD_W-1:0] left;
        logic [SCOORD_W-1:0] top;
        logic [COORD_W-1:0]  width;
        logic [COORD_W-1:0]  height;
        logic [FRAME_W-1:0]  frame;
    } t_crop;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       start          = 1'b0;
    logic                       i_cfg_we       = 1'b0;
    logic [CNT_W-1:0]           i_cfg_data     = '0;
    logic                       i_cmd          = 1'b0;
    logic [IDX_W-1:0]           i_key_index    = '0;
    logic [FRAME_W-1:0]         i_key_frame    = '0;
    logic [COORD_W-1:0]         i_key_center_x = '0;
    logic [COORD_W-1:0]         i_key_center_y = '0;
    logic [COORD_W-1:0]         i_key_width    = '0;
    logic [COORD_W-1:0]         i_key_height   = '0;
    logic                       busy;
    logic                       o_valid;
    logic signed [SCOORD_W-1:0] o_crop_left;
    logic signed [SCOORD_W-1:0] o_crop_top;
    logic [COORD_W-1:0]         o_crop_width;
    logic [COORD_W-1:0]         o_crop_height;
    logic [FRAME_W-1:0]         o_frame_number;

    t_step            step_q[$];
    t_step            cur_step;
    t_crop            rects_due[$];

    kci_pkg::t_key    key_tbl[MAX_KEYS];
    logic [CNT_W-1:0] keys_live = 1;
    int unsigned      seg_idx = 0;
    logic [FRAME_W-1:0] frame_ctr = '0;
    int unsigned      deepest_seg = 0;

    logic [FRAME_W-1:0] gen_fc = '0;
    int               gen_items = 0;
    int               total_items = ITEM_TARGET;
    int               items_taken = 0;
    int               writes_taken = 0;
    int               frames_sent = 0;
    int               results_got = 0;
    int               cfg_writes = 0;
    int               quiet = 0;
    int               stall_cycles = 0;
    int               err_count = 0;

    keyframe_crop_interpolator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_key_index    (i_key_index),
        .i_key_frame    (i_key_frame),
        .i_key_center_x (i_key_center_x),
        .i_key_center_y (i_key_center_y),
        .i_key_width    (i_key_width),
        .i_key_height   (i_key_height),
        .o_valid        (o_valid),
        .o_crop_left    (o_crop_left),
        .o_crop_top     (o_crop_top),
        .o_crop_width   (o_crop_width),
        .o_crop_height  (o_crop_height),
        .o_frame_number (o_frame_number)
    );

    initial begin : clk_gen
        forever #5 i_clk = ~i_clk;
    end

    initial begin : rst_gen
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%h, expected 0x%h", $realtime, field, got, want);
        err_count++;
    endtask

    function automatic logic [COORD_W-1:0] blend_coord(input logic [COORD_W-1:0] a,
                                                       input logic [COORD_W-1:0] b,
                                                       input logic [FRAME_W-1:0] elapsed,
                                                       input logic [FRAME_W-1:0] span);
        longint num;
        longint den;
        longint q;
        num = longint'(elapsed) * (longint'(b) - longint'(a));
        den = longint'(span);
        if (num >= 0) begin
            q = num / den;
        end else begin
            q = -((-num + den - 1) / den);
        end
        return COORD_W'(longint'(a) + q);
    endfunction

    function automatic t_crop crop_for_frame();
        t_crop         res;
        int unsigned   eff;
        int unsigned   last;
        kci_pkg::t_key lo;
        kci_pkg::t_key hi;
        eff = (keys_live == 0) ? 1 : ((keys_live > MAX_KEYS) ? MAX_KEYS : keys_live);
        last = eff - 1;
        if (seg_idx > last) seg_idx = last;
        while (seg_idx < last && frame_ctr >= key_tbl[seg_idx + 1].frame) seg_idx++;
        if (seg_idx > deepest_seg) deepest_seg = seg_idx;
        lo = key_tbl[seg_idx];
        if (seg_idx < last && frame_ctr >= lo.frame) begin
            hi = key_tbl[seg_idx + 1];
            lo.cx = blend_coord(lo.cx, hi.cx, frame_ctr - lo.frame, hi.frame - lo.frame);
            lo.cy = blend_coord(lo.cy, hi.cy, frame_ctr - lo.frame, hi.frame - lo.frame);
            lo.w  = blend_coord(lo.w, hi.w, frame_ctr - lo.frame, hi.frame - lo.frame);
            lo.h  = blend_coord(lo.h, hi.h, frame_ctr - lo.frame, hi.frame - lo.frame);
        end
        res.left   = {1'b0, lo.cx} - {2'b00, lo.w[COORD_W-1:1]};
        res.top    = {1'b0, lo.cy} - {2'b00, lo.h[COORD_W-1:1]};
        res.width  = lo.w;
        res.height = lo.h;
        res.frame  = frame_ctr;
        frame_ctr  = frame_ctr + 1;
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    function automatic kci_pkg::t_key rand_key(input logic [FRAME_W-1:0] frame);
        kci_pkg::t_key key;
        key.frame = frame;
        key.cx    = rand_coord();
        key.cy    = rand_coord();
        key.w     = rand_coord();
        key.h     = rand_coord();
        return key;
    endfunction

    task automatic push_step(input t_step_kind kind, input logic cmd,
                             input logic [IDX_W-1:0] idx, input kci_pkg::t_key key,
                             input logic [CNT_W-1:0] cfg);
        t_step s;
        s.kind = kind;
        s.cmd  = cmd;
        s.idx  = idx;
        s.key  = key;
        s.cfg  = cfg;
        step_q.insert(step_q.size(), s);
        if (kind == STEP_ITEM) gen_items++;
    endtask

    task automatic push_frame();
        push_step(STEP_ITEM, kci_pkg::CMD_FRAME, IDX_W'($urandom()), rand_key($urandom()),
                  '0);
        gen_fc = gen_fc + 1;
    endtask

    task automatic push_key(input logic [IDX_W-1:0] idx, input logic [FRAME_W-1:0] frame,
                            input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
        kci_pkg::t_key key;
        key.frame = frame;
        key.cx    = cx;
        key.cy    = cy;
        key.w     = w;
        key.h     = h;
        push_step(STEP_ITEM, kci_pkg::CMD_WRITE, idx, key, '0);
    endtask

    // drive items and count writes; predict at each accepted frame item
    always @(posedge i_clk) begin : drive_proc
        logic  nxt_start;
        logic  nxt_we;
        int    idle_pct;
        t_step head;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                keys_live = i_cfg_data;
                cfg_writes++;
            end
            if (start && !busy) begin
                items_taken++;
                if (cur_step.cmd == kci_pkg::CMD_WRITE) begin
                    key_tbl[cur_step.idx] = cur_step.key;
                    writes_taken++;
                end else begin
                    rects_due.insert(rects_due.size(), crop_for_frame());
                    frames_sent++;
                end
                nxt_start = 1'b0;
                quiet = 0;
            end else if (quiet < GUARD) begin
                quiet++;
            end
            idle_pct = (items_taken < total_items / 3) ? 31 :
                       (items_taken < 2 * total_items / 3) ? 67 : 0;
            if (!nxt_start && !i_cfg_we && step_q.size() > 0) begin
                head = step_q[0];
                case (head.kind)
                    STEP_ITEM: begin
                        if ($urandom_range(99) >= idle_pct) begin
                            void'(step_q.pop_front());
                            cur_step       = head;
                            i_cmd          <= head.cmd;
                            i_key_index    <= head.idx;
                            i_key_frame    <= head.key.frame;
                            i_key_center_x <= head.key.cx;
                            i_key_center_y <= head.key.cy;
                            i_key_width    <= head.key.w;
                            i_key_height   <= head.key.h;
                            nxt_start      = 1'b1;
                        end
                    end
                    STEP_CONFIG: begin
                        if (frames_sent == results_got && quiet >= GUARD && !busy) begin
                            void'(step_q.pop_front());
                            i_cfg_data <= head.cfg;
                            nxt_we     = 1'b1;
                        end
                    end
                    default: begin
                        if (frames_sent == results_got) void'(step_q.pop_front());
                    end
                endcase
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    always @(posedge i_clk) begin : check_proc
        t_crop want;
        if (i_rst_n && o_valid) begin
            results_got <= results_got + 1;
            if (rects_due.size() == 0) begin
                report_mismatch("unexpected rectangle, frame_number", o_frame_number, '0);
            end else begin
                want = rects_due.pop_front();
                if (o_crop_left !== want.left)
                    report_mismatch("crop_left", 32'(o_crop_left), 32'(want.left));
                if (o_crop_top !== want.top)
                    report_mismatch("crop_top", 32'(o_crop_top), 32'(want.top));
                if (o_crop_width !== want.width)
                    report_mismatch("crop_width", 32'(o_crop_width), 32'(want.width));
                if (o_crop_height !== want.height)
                    report_mismatch("crop_height", 32'(o_crop_height), 32'(want.height));
                if (o_frame_number !== want.frame)
                    report_mismatch("frame_number", o_frame_number, want.frame);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no activity for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin : stim_proc
        logic [CNT_W-1:0]   cfg_val;
        int unsigned        eff;
        int unsigned        gap_max;
        int unsigned        nframes;
        logic               broken;
        logic [FRAME_W-1:0] key_at;
        logic [FRAME_W-1:0] first_key;
        int                 k;

        // directed: zero count, frames before keyframe 0, extreme coordinates
        push_step(STEP_CONFIG, kci_pkg::CMD_WRITE, '0, '0, 0);
        push_key(0, 5, '1, '0, '0, '1);
        push_frame();
        push_frame();
        push_key(1, 9, '0, '1, '1, '0);
        push_key(2, '1, 13'd4096, 13'd4095, 13'd8190, 13'd1);
        push_step(STEP_CONFIG, kci_pkg::CMD_WRITE, '0, '0, 3);
        repeat (9) push_frame();
        // segment beyond the valid count is pulled back
        push_step(STEP_CONFIG, kci_pkg::CMD_WRITE, '0, '0, 1);
        push_frame();
        push_key('1, '0, 13'h1555, 13'h0AAA, '1, '1);
        push_step(STEP_DRAIN, kci_pkg::CMD_WRITE, '0, '0, '0);
        push_frame();

        while (gen_items < ITEM_TARGET) begin
            case ($urandom_range(9))
                0: cfg_val = CNT_W'(MAX_KEYS);
                1: cfg_val = CNT_W'($urandom_range(127, MAX_KEYS + 1));
                2: cfg_val = CNT_W'($urandom_range(1));
                3, 4, 5: cfg_val = CNT_W'($urandom_range(4, 2));
                default: cfg_val = CNT_W'($urandom_range(16, 2));
            endcase
            eff = (cfg_val == 0) ? 1 : ((cfg_val > MAX_KEYS) ? MAX_KEYS : cfg_val);
            broken = ($urandom_range(7) == 0);
            gap_max = (eff > 16) ? 3 : 8;
            push_step(STEP_CONFIG, kci_pkg::CMD_WRITE, '0, '0, 1);
            key_at = gen_fc + 1 + $urandom_range(6) - 3;
            first_key = key_at;
            for (k = 0; k < eff; k++) begin
                push_step(STEP_ITEM, kci_pkg::CMD_WRITE, IDX_W'(k), rand_key(key_at), '0);
                if (broken)
                    key_at = key_at + (($urandom_range(2) == 0) ? $urandom()
                                                               : $urandom_range(8) - 3);
                else
                    key_at = key_at + $urandom_range(gap_max, 1);
            end
            // count of one: pull the segment back to keyframe 0
            push_frame();
            push_step(STEP_CONFIG, kci_pkg::CMD_WRITE, '0, '0, cfg_val);
            nframes = broken ? $urandom_range(24, 4)
                             : int'(key_at - first_key) + $urandom_range(6, 2);
            for (k = 0; k < nframes; k++) begin
                if ($urandom_range(11) == 0)
                    push_step(STEP_ITEM, kci_pkg::CMD_WRITE, IDX_W'($urandom()),
                              rand_key($urandom()), '0);
                if ($urandom_range(39) == 0)
                    push_step(STEP_DRAIN, kci_pkg::CMD_WRITE, '0, '0, '0);
                push_frame();
            end
        end
        total_items = gen_items;

        while (step_q.size() > 0 || start || results_got < frames_sent) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (rects_due.size() != 0)
            report_mismatch("rectangles never emitted", rects_due.size(), 0);

        $display("Ran %0d items: %0d keyframe writes, %0d frames, %0d count writes",
                 items_taken, writes_taken, frames_sent, cfg_writes);
        $display("Checked %0d rectangles, deepest segment %0d, last frame %0d",
                 results_got, deepest_seg, frame_ctr);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/kci_pkg.sv
sv/kci_lerp_lane.sv
sv/keyframe_crop_interpolator_unit.sv
verif/tb_top.sv
